// ----- rtl/bbc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bbc_pkg
// Shared types and constants of the bracket balance checker.
// ============================================================================
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CH_W            = 8;
    localparam int KIND_W          = 2;
    localparam int CODE_W          = 3;
    localparam int OPEN_W          = 7;

    // Bracket characters.
    localparam logic [CH_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [CH_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [CH_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CH_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [CH_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CH_W-1:0] CH_CLOSE_SQUARE = 8'h5D;

    // Bracket kinds as stored on the stack.
    localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    typedef enum logic [CODE_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_MISMATCH = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_UNCLOSED = 3'd3,
        ERR_OVERFLOW = 3'd4
    } err_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        op_t               op;
        logic [KIND_W-1:0] kind;
        logic              last;
    } bbc_op_t;

endpackage

// ----- rtl/bracket_balance_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bracket_balance_checker
// Checks that round, curly and square brackets in a byte stream nest and
// match, giving one verdict item per expression.
// ============================================================================
//
//   Channel  Handshake             Payload                          Role
//   -------  --------------------  -------------------------------  ---------
//   in       in_valid / in_ready   ch[7:0], last                    one char
//   out      out_valid / out_ready balanced, error_code[2:0],       verdict
//                                  open_left[6:0]
//
// One character item is accepted per cycle while the queue has space. An
// item is first registered in the queue; the stack engine then executes it
// and, for an item marked last, loads the verdict into the output register.
// The rate is set by the stack engine: one push or pop per cycle unless a
// last item waits on a stalled output. The top two kinds are in registers
// and the stack memory is read at most once a cycle to refill the lower one.
// Reset clears the depth, the latched error and all valid flags; the stack
// memory is not cleared, since an unwritten entry is never used.
// A stalled output blocks only items marked last; other items keep draining,
// and the two-entry queue lets the input side run while the engine waits.
//
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CH_W-1:0]   ch,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              balanced,
    output logic [CODE_W-1:0] error_code,
    output logic [OPEN_W-1:0] open_left
);

    // Classified item from the decoder, before it enters the queue.
    bbc_op_t front_item;

    // Queue output toward the stack engine.
    bbc_op_t q_item;
    logic    q_valid;
    logic    q_ready;

    // The front decodes each character into a push, a pop or nothing. It is
    // purely combinational, so acceptance depends only on queue space.
    bbc_front u_front (
        .ch      (ch),
        .last    (last),
        .op_item (front_item)
    );

    // The queue decouples the input from the engine, so that a stalled
    // verdict does not immediately push back on the character stream.
    bbc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_item  (front_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // The back executes stack operations, latches the first error and
    // registers the verdict when the last item of an expression arrives.
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .balanced   (balanced),
        .error_code (error_code),
        .open_left  (open_left)
    );

endmodule

// ----- rtl/bbc_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bbc_front
// Decodes each character into a push, a pop or nothing, with its kind.
// ============================================================================
module bbc_front
    import bbc_pkg::*;
(
    input  logic [CH_W-1:0] ch,
    input  logic            last,
    output bbc_op_t         op_item
);

    always_comb
    begin
        op_item.op   = OP_NONE;
        op_item.kind = KIND_ROUND;
        op_item.last = last;
        case (ch)
            CH_OPEN_ROUND:
            begin
                op_item.op   = OP_PUSH;
                op_item.kind = KIND_ROUND;
            end
            CH_OPEN_CURLY:
            begin
                op_item.op   = OP_PUSH;
                op_item.kind = KIND_CURLY;
            end
            CH_OPEN_SQUARE:
            begin
                op_item.op   = OP_PUSH;
                op_item.kind = KIND_SQUARE;
            end
            CH_CLOSE_ROUND:
            begin
                op_item.op   = OP_POP;
                op_item.kind = KIND_ROUND;
            end
            CH_CLOSE_CURLY:
            begin
                op_item.op   = OP_POP;
                op_item.kind = KIND_CURLY;
            end
            CH_CLOSE_SQUARE:
            begin
                op_item.op   = OP_POP;
                op_item.kind = KIND_SQUARE;
            end
            default:
            begin
                op_item.op   = OP_NONE;
                op_item.kind = KIND_ROUND;
            end
        endcase
    end

endmodule

// ----- rtl/bbc_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bbc_queue
// Two-entry queue of classified items between the front and the back.
// ============================================================================
module bbc_queue
    import bbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    output logic    wr_ready,
    input  bbc_op_t wr_item,
    output logic    rd_valid,
    input  logic    rd_ready,
    output bbc_op_t rd_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bbc_op_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- rtl/bbc_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bbc_back
// Bracket stack engine: pushes and pops kinds, latches the first error and
// forms the verdict on the last item of each expression.
// ============================================================================
module bbc_back
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  bbc_op_t           q_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              balanced,
    output logic [CODE_W-1:0] error_code,
    output logic [OPEN_W-1:0] open_left
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);

    // The top two kinds live in registers; the memory holds every pushed kind
    // and refills the second-from-top register on a pop.
    logic [KIND_W-1:0]  kind_mem [STACK_DEPTH];
    logic [KIND_W-1:0]  top_reg, below_reg;

    logic [DEPTH_W-1:0] depth_reg, depth_next, depth_after;
    err_t               err_reg, err_next, err_after, verdict;
    logic               out_valid_reg, out_valid_next;
    logic               balanced_reg;
    err_t               code_reg;
    logic [OPEN_W-1:0]  open_reg;

    logic               fire, active, full, empty;
    logic               do_push, do_pop, ovf, close_empty, mismatch;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;

    assign q_ready     = !q_item.last || !out_valid_reg || out_ready;
    assign fire        = q_valid && q_ready;
    assign active      = fire && (err_reg == ERR_NONE);
    assign full        = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign empty       = (depth_reg == '0);
    assign do_push     = active && (q_item.op == OP_PUSH) && !full;
    assign ovf         = active && (q_item.op == OP_PUSH) && full;
    assign do_pop      = active && (q_item.op == OP_POP) && !empty;
    assign close_empty = active && (q_item.op == OP_POP) && empty;
    assign mismatch    = do_pop && (top_reg != q_item.kind);
    assign wr_addr     = depth_reg[ADDR_W-1:0];
    assign rd_addr     = ADDR_W'(depth_reg - DEPTH_W'(3));

    always_comb
    begin
        depth_after = depth_reg;
        if (do_push)
        begin
            depth_after = depth_reg + 1'b1;
        end
        else if (do_pop)
        begin
            depth_after = depth_reg - 1'b1;
        end

        err_after = err_reg;
        if (ovf)
        begin
            err_after = ERR_OVERFLOW;
        end
        else if (close_empty)
        begin
            err_after = ERR_EMPTY;
        end
        else if (mismatch)
        begin
            err_after = ERR_MISMATCH;
        end

        verdict = err_after;
        if ((err_after == ERR_NONE) && (depth_after != '0))
        begin
            verdict = ERR_UNCLOSED;
        end

        depth_next = depth_after;
        err_next   = err_after;
        if (fire && q_item.last)
        begin
            depth_next = '0;
            err_next   = ERR_NONE;
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (fire && q_item.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            kind_mem[wr_addr] <= q_item.kind;
            top_reg           <= q_item.kind;
            below_reg         <= top_reg;
        end
        else if (do_pop)
        begin
            top_reg   <= below_reg;
            below_reg <= kind_mem[rd_addr];
        end
        if (fire && q_item.last)
        begin
            balanced_reg <= (verdict == ERR_NONE);
            code_reg     <= verdict;
            open_reg     <= OPEN_W'(depth_after);
        end
    end

    assign out_valid  = out_valid_reg;
    assign balanced   = balanced_reg;
    assign error_code = code_reg;
    assign open_left  = open_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && q_item.last |=> (depth_reg == '0) && (err_reg == ERR_NONE))
        else $error("state not cleared after last item");

    a_frozen_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !q_item.last && (err_reg != ERR_NONE) |=> $stable(depth_reg))
        else $error("stack moved after an error");

    a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (balanced_reg == (code_reg == ERR_NONE)))
        else $error("balanced flag disagrees with error code");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(code_reg))
        else $error("pending result lost");

endmodule

// ----- dv/bracket_balance_checker_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bracket_balance_checker_tb
// Self-checking bench for the bracket balance checker. Character items are
// queued up front, driven with random gaps and checked against a behavioral
// stack predictor that yields one verdict per expression.
// ============================================================================
module bracket_balance_checker_tb;

    import bbc_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int RANDOM_CHARS = 300;
    localparam int HOLD_AT      = 250;    // items taken before the long output stall
    localparam int LONG_HOLD    = 300;    // cycles of that stall
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;

    // One character item waiting to be driven. gap is the number of idle
    // cycles after it is taken; settle holds it back until no verdict is owed.
    typedef struct {
        logic [CH_W-1:0] c;
        logic            is_last;
        int              gap;
        bit              settle;
    } char_item_t;

    // One expected verdict, at the widths of the output ports.
    typedef struct packed {
        logic              balanced;
        err_t              code;
        logic [OPEN_W-1:0] open_left;
    } verdict_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [CH_W-1:0]   ch = '0;
    logic              last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              balanced;
    logic [CODE_W-1:0] error_code;
    logic [OPEN_W-1:0] open_left;

    char_item_t pending_chars[$];
    verdict_t   expected_verdicts[$];
    char_item_t head_item;

    // Predictor state: a private copy of the bracket stack.
    logic [KIND_W-1:0] stack_kinds [DEPTH];
    int                stack_fill = 0;
    err_t              latched_err = ERR_NONE;

    int  mismatches    = 0;
    int  verdicts_seen = 0;
    int  chars_taken   = 0;
    int  cycle_count   = 0;
    int  gap_left      = 0;
    int  hold_left     = 0;
    int  rx_calm_left  = 0;
    int  calm_left     = 0;
    bit  long_hold_done = 1'b0;
    bit  pause_next    = 1'b0;

    bracket_balance_checker #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .balanced  (balanced),
        .error_code(error_code),
        .open_left (open_left)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Applies one character to the predicted stack. Returns 1 and fills
    // verdict when the character closes the expression; the stack then
    // starts over empty, as the block does.
    function automatic bit predict_char(input logic [CH_W-1:0] c, input logic is_last,
                                        output verdict_t verdict);
        bit                is_open;
        bit                is_close;
        logic [KIND_W-1:0] k;
        err_t              code;
        is_open  = 1'b0;
        is_close = 1'b0;
        k        = KIND_ROUND;
        verdict  = '0;
        case (c)
            CH_OPEN_ROUND:   begin is_open  = 1'b1; k = KIND_ROUND;  end
            CH_OPEN_CURLY:   begin is_open  = 1'b1; k = KIND_CURLY;  end
            CH_OPEN_SQUARE:  begin is_open  = 1'b1; k = KIND_SQUARE; end
            CH_CLOSE_ROUND:  begin is_close = 1'b1; k = KIND_ROUND;  end
            CH_CLOSE_CURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
            CH_CLOSE_SQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
            default:         ;
        endcase

        // Once an error has latched, the stack is frozen until the end.
        if (latched_err == ERR_NONE)
        begin
            if (is_open)
            begin
                if (stack_fill < DEPTH)
                begin
                    stack_kinds[stack_fill] = k;
                    stack_fill++;
                end
                else
                begin
                    // A full stack refuses the push and the depth stays put.
                    latched_err = ERR_OVERFLOW;
                end
            end
            else if (is_close)
            begin
                if (stack_fill == 0)
                begin
                    latched_err = ERR_EMPTY;
                end
                else
                begin
                    // A wrong kind is still popped before the error latches.
                    stack_fill--;
                    if (stack_kinds[stack_fill] != k)
                        latched_err = ERR_MISMATCH;
                end
            end
        end

        if (!is_last)
            return 1'b0;

        code = latched_err;
        if (code == ERR_NONE && stack_fill != 0)
            code = ERR_UNCLOSED;
        verdict.balanced  = (code == ERR_NONE);
        verdict.code      = code;
        verdict.open_left = OPEN_W'(stack_fill);
        stack_fill  = 0;
        latched_err = ERR_NONE;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [CH_W-1:0] open_char(input logic [KIND_W-1:0] k);
        case (k)
            KIND_ROUND: return CH_OPEN_ROUND;
            KIND_CURLY: return CH_OPEN_CURLY;
            default:    return CH_OPEN_SQUARE;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] close_char(input logic [KIND_W-1:0] k);
        case (k)
            KIND_ROUND: return CH_CLOSE_ROUND;
            KIND_CURLY: return CH_CLOSE_CURLY;
            default:    return CH_CLOSE_SQUARE;
        endcase
    endfunction

    function automatic bit is_bracket(input logic [CH_W-1:0] c);
        return c == CH_OPEN_ROUND  || c == CH_CLOSE_ROUND  ||
               c == CH_OPEN_CURLY  || c == CH_CLOSE_CURLY  ||
               c == CH_OPEN_SQUARE || c == CH_CLOSE_SQUARE;
    endfunction

    function automatic logic [KIND_W-1:0] random_kind();
        return KIND_W'($urandom_range(2));
    endfunction

    function automatic logic [CH_W-1:0] random_bracket();
        if ($urandom_range(1) == 0)
            return open_char(random_kind());
        return close_char(random_kind());
    endfunction

    // Any byte over the full 8-bit range that the block ignores.
    function automatic logic [CH_W-1:0] filler_char();
        logic [CH_W-1:0] c;
        c = CH_W'($urandom_range(255));
        while (is_bracket(c))
            c = CH_W'($urandom_range(255));
        return c;
    endfunction

    // Queues one item. Idle gaps are mostly short, now and then long, with
    // calm stretches in which the sender offers an item every cycle, settle pauses apart.
    task automatic push_char(input logic [CH_W-1:0] c, input logic is_last);
        char_item_t it;
        int         pick;
        it.c       = c;
        it.is_last = is_last;
        it.settle  = pause_next;
        pause_next = 1'b0;
        if (calm_left > 0)
        begin
            calm_left--;
            it.gap = 0;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                calm_left = $urandom_range(20, 60);
                it.gap    = 0;
            end
            else if (pick < 70)
                it.gap = 0;
            else if (pick < 96)
                it.gap = $urandom_range(1, 3);
            else
                it.gap = $urandom_range(10, 40);
        end
        pending_chars.push_back(it);
    endtask

    // Queues a whole expression; its final character carries last.
    task automatic emit_text(input logic [CH_W-1:0] text[$]);
        foreach (text[i])
            push_char(text[i], i == text.size() - 1);
    endtask

    task automatic add_string(input string s);
        logic [CH_W-1:0] text[$];
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        emit_text(text);
    endtask

    // A well-formed expression with random nesting and filler. When broken
    // is set, one of three faults is injected: a random bracket overwrites
    // some position, the final character is dropped, or a stray
    // closing bracket is appended.
    task automatic add_expr(input int steps, input int max_nest, input bit broken);
        logic [CH_W-1:0]   text[$];
        logic [KIND_W-1:0] open_kinds[$];
        logic [KIND_W-1:0] k;
        int                pick;
        for (int i = 0; i < steps; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 35 && open_kinds.size() < max_nest)
            begin
                k = random_kind();
                open_kinds.push_back(k);
                text.push_back(open_char(k));
            end
            else if (pick < 70 && open_kinds.size() > 0)
                text.push_back(close_char(open_kinds.pop_back()));
            else
                text.push_back(filler_char());
        end
        while (open_kinds.size() > 0)
            text.push_back(close_char(open_kinds.pop_back()));
        if (text.size() == 0)
            text.push_back(filler_char());
        if (broken)
        begin
            pick = $urandom_range(2);
            if (pick == 0)
                text[$urandom_range(text.size() - 1)] = random_bracket();
            else if (pick == 1 && text.size() > 1)
                void'(text.pop_back());
            else
                text.push_back(close_char(random_kind()));
        end
        emit_text(text);
    endtask

    // Byte soup, half of it brackets, so every bit of ch toggles.
    task automatic add_noise(input int len);
        logic [CH_W-1:0] text[$];
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(1) == 0)
                text.push_back(CH_W'($urandom_range(255)));
            else
                text.push_back(random_bracket());
        end
        emit_text(text);
    endtask

    // A run of opening brackets near or past the stack depth, optionally
    // followed by the matching closes.
    task automatic add_deep(input int n, input bit close_all);
        logic [CH_W-1:0]   text[$];
        logic [KIND_W-1:0] open_kinds[$];
        logic [KIND_W-1:0] k;
        for (int i = 0; i < n; i++)
        begin
            k = random_kind();
            open_kinds.push_back(k);
            text.push_back(open_char(k));
        end
        if (close_all)
        begin
            while (open_kinds.size() > 0)
                text.push_back(close_char(open_kinds.pop_back()));
        end
        emit_text(text);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the queued items. valid and the payload only change
    // once the current item has been taken or nothing is offered.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_chars.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (pending_chars[0].settle && (in_valid || expected_verdicts.size() != 0))
            begin
                // Pause the sender until every owed verdict has come back.
                // An item taken at this edge is predicted at this edge too, so drop
                // valid first and trust the queue size only once nothing is offered.
                in_valid <= 1'b0;
            end
            else
            begin
                head_item = pending_chars.pop_front();
                ch       <= head_item.c;
                last     <= head_item.is_last;
                in_valid <= 1'b1;
                gap_left  = head_item.gap;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready with short and long stalls, calm stretches,
    // and one long hold-off that lets verdicts back up into the input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        int pick;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && chars_taken >= HOLD_AT)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            out_ready     <= 1'b0;
        end
        else if (rx_calm_left > 0)
        begin
            rx_calm_left--;
            out_ready <= 1'b1;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                rx_calm_left = $urandom_range(20, 80);
                out_ready   <= 1'b1;
            end
            else if (pick < 78)
                out_ready <= 1'b1;
            else if (pick < 97)
            begin
                hold_left  = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
            begin
                hold_left  = $urandom_range(20, 60);
                out_ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every taken item, then checks every taken verdict
    // against the oldest expectation. Both happen in this one process so the
    // order of push and pop never depends on the simulator.
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        verdict_t predicted;
        verdict_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                chars_taken++;
                if (predict_char(ch, last, predicted))
                    expected_verdicts.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                verdicts_seen++;
                if (expected_verdicts.size() == 0)
                begin
                    note_mismatch($sformatf(
                        "verdict %0d: none expected, got balanced=%0b code=%0d open_left=%0d",
                        verdicts_seen, balanced, error_code, open_left));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (balanced !== want.balanced || error_code !== want.code ||
                        open_left !== want.open_left)
                    begin
                        note_mismatch($sformatf(
                            {"verdict %0d: expected balanced=%0b code=%0d open_left=%0d,",
                             " got balanced=%0b code=%0d open_left=%0d"},
                            verdicts_seen, want.balanced, want.code, want.open_left,
                            balanced, error_code, open_left));
                    end
                end
            end
        end
    end

    // A run that never drains ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bracket_balance_checker: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        int target;
        int pick;

        // Directed part: ignored bytes at both ends of the range, plain
        // nesting, a mismatch, a close on an empty stack, brackets left
        // open, characters after an error, and a bracket as the final item.
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        add_string("()");
        add_string("{[]}");
        add_string("(]");
        add_string(")(");
        add_string("[{");
        add_string("(})a");
        add_string("[[)]");

        // Exactly full stack, then a push beyond it.
        add_deep(DEPTH, 1'b1);
        add_deep(DEPTH + 1, 1'b0);

        // Random part, mostly well-formed expressions so the stack gets
        // exercised, with broken ones, noise and the odd deep run mixed in.
        pause_next = 1'b1;
        target = pending_chars.size() + RANDOM_CHARS;
        while (pending_chars.size() < target)
        begin
            if ($urandom_range(99) < 3)
                pause_next = 1'b1;
            pick = $urandom_range(99);
            if (pick < 55)
                add_expr($urandom_range(1, 16), $urandom_range(1, 8), 1'b0);
            else if (pick < 70)
                add_noise($urandom_range(1, 10));
            else if (pick < 98)
                add_expr($urandom_range(1, 16), $urandom_range(1, 8), 1'b1);
            else
                add_deep($urandom_range(DEPTH - 2, DEPTH + 2), 1'($urandom_range(1)));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("bracket_balance_checker: match");
        else
            $display("bracket_balance_checker: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bbc_pkg.sv
rtl/bbc_front.sv
rtl/bbc_queue.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker.sv
dv/bracket_balance_checker_tb.sv
